>>> src/assert_macros.svh
// assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CPS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define CPS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/cps_pkg.sv
// shared types, codes and widths of the cpu process scheduler
package cps_pkg;

  localparam int DEF_MAX_PROCS = 16;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 56;

  localparam logic [23:0] CYCLE_MAX = 24'hFFFFFF;
  localparam logic [15:0] SLICE_MAX = 16'hFFFF;

  // input item kinds
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // scheduling algorithms
  localparam logic [2:0] ALG_FIFO = 3'd0;
  localparam logic [2:0] ALG_SJF  = 3'd1;
  localparam logic [2:0] ALG_SRT  = 3'd2;
  localparam logic [2:0] ALG_PRIO = 3'd3;
  localparam logic [2:0] ALG_RR   = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_ALGO    = 2'd0;
  localparam logic [1:0] REG_QUANTUM = 2'd1;
  localparam logic [1:0] REG_PCOUNT  = 2'd2;

  // datapath operations
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE   = 4'd0;
  localparam logic [OP_W-1:0] OP_ACCEPT = 4'd1;
  localparam logic [OP_W-1:0] OP_START  = 4'd2;
  localparam logic [OP_W-1:0] OP_ARR    = 4'd3;
  localparam logic [OP_W-1:0] OP_SEL    = 4'd4;
  localparam logic [OP_W-1:0] OP_SCAN   = 4'd5;
  localparam logic [OP_W-1:0] OP_DEC    = 4'd6;
  localparam logic [OP_W-1:0] OP_TAKE   = 4'd7;
  localparam logic [OP_W-1:0] OP_SHIFT  = 4'd8;
  localparam logic [OP_W-1:0] OP_RUN    = 4'd9;
  localparam logic [OP_W-1:0] OP_DONE   = 4'd10;
  localparam logic [OP_W-1:0] OP_RES    = 4'd11;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_end;
    logic sel_scan;
    logic sel_take;
    logic dec_take;
    logic out_free;
  } dp_status_t;

endpackage

>>> src/cps_datapath.sv
// scheduler datapath: process tables, ready queue, run state and result register
module cps_datapath import cps_pkg::*; #(
  parameter int MAX_PROCS = DEF_MAX_PROCS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            status,
  input  logic [1:0]            in_command,
  input  logic [IN_DATA_W-1:0]  in_data,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_data,
  output logic                  m_valid,
  input  logic                  m_ready,
  output logic [OUT_DATA_W-1:0] m_data
);

  localparam int SW = $clog2(MAX_PROCS);
  localparam int CW = $clog2(MAX_PROCS + 1);

  // configuration
  logic [2:0]  algo;
  logic [15:0] quantum;
  logic [4:0]  pcount;

  // tables and queue
  logic [15:0]   arr_mem [MAX_PROCS];
  logic [15:0]   bur_mem [MAX_PROCS];
  logic [7:0]    pri_mem [MAX_PROCS];
  logic [15:0]   rem_mem [MAX_PROCS];
  logic          fin     [MAX_PROCS];
  logic [SW-1:0] q_mem   [MAX_PROCS];

  // run state
  logic [CW-1:0] qlen, qlen_next;
  logic          cv;
  logic [SW-1:0] cur;
  logic [15:0]   slice;
  logic [23:0]   next_cycle;

  // per item working registers
  logic [1:0]    in_cmd;
  logic [23:0]   cyc;
  logic [CW-1:0] idx;
  logic          found;
  logic [SW-1:0] best_pos;
  logic [15:0]   best_key;
  logic          push_cur;
  logic [SW-1:0] taken;
  logic          ran, comp, done_acc;

  logic [3:0]  in_pidx;
  logic [15:0] in_arr, in_bur;
  logic [7:0]  in_pri;
  logic        load_ok;

  logic [CW-1:0] n_valid, lim;
  logic [SW-1:0] ia, tab_a, q_rd;
  logic [15:0]   arr_rd, bur_rd, rem_rd, key;
  logic [7:0]    pri_rd;
  logic          fin_rd;
  logic          scan_end, idx_lt_n, arr_alg, alg13;
  logic          scan_hit, cur_arr;
  logic          sel_scan, sel_take, sel_push, sel_rr_clear;
  logic          dec_take, dec_drop;
  logic [15:0]   rem_dec;
  logic          run_fin;
  logic          push_req;
  logic          q_we;
  logic [SW-1:0] q_wa, q_wd;
  logic          out_free, res_load;
  logic [23:0]   o_tick;
  logic [3:0]    o_slot;
  logic [24:0]   o_ccyc;
  logic          o_done;

  assign in_pidx = in_data[3:0];
  assign in_arr  = in_data[19:4];
  assign in_bur  = in_data[35:20];
  assign in_pri  = in_data[43:36];
  assign load_ok = 32'(in_pidx) < MAX_PROCS;

  // valid entry count clipped to table depth
  always_comb begin
    if (32'(pcount) > MAX_PROCS) n_valid = CW'(MAX_PROCS);
    else n_valid = CW'(pcount);
  end

  // single read address per table
  assign ia   = idx[SW-1:0];
  assign q_rd = q_mem[ia];
  always_comb begin
    case (cmd.op)
      OP_SCAN:        tab_a = q_rd;
      OP_DEC, OP_RUN: tab_a = cur;
      default:        tab_a = ia;
    endcase
  end
  assign arr_rd = arr_mem[tab_a];
  assign bur_rd = bur_mem[tab_a];
  assign pri_rd = pri_mem[tab_a];
  assign rem_rd = rem_mem[tab_a];
  assign fin_rd = fin[tab_a];

  assign arr_alg = (algo == ALG_FIFO) || (algo == ALG_SRT) || (algo == ALG_RR);
  assign alg13   = (algo == ALG_SJF) || (algo == ALG_PRIO);

  // scan limit for the running operation
  always_comb begin
    case (cmd.op)
      OP_START:           lim = CW'(MAX_PROCS);
      OP_ARR:             lim = arr_alg ? n_valid : '0;
      OP_SCAN, OP_SHIFT:  lim = qlen;
      OP_DONE:            lim = n_valid;
      default:            lim = '0;
    endcase
  end
  assign scan_end = idx >= lim;
  assign idx_lt_n = idx < n_valid;

  // scan key and best-entry test
  always_comb begin
    case (algo)
      ALG_SJF: key = bur_rd;
      ALG_SRT: key = rem_rd;
      default: key = {8'd0, pri_rd};
    endcase
  end
  assign scan_hit = ({8'd0, arr_rd} <= cyc) && (!found || key < best_key);

  // selection decision before any scan
  always_comb begin
    sel_scan     = 1'b0;
    sel_take     = 1'b0;
    sel_push     = 1'b0;
    sel_rr_clear = 1'b0;
    case (algo)
      ALG_FIFO: sel_take = !cv && (qlen != '0);
      ALG_SJF:  sel_scan = !cv;
      ALG_SRT, ALG_PRIO: sel_scan = 1'b1;
      ALG_RR: begin
        sel_push     = cv && (slice >= quantum);
        sel_take     = (qlen != '0) && (sel_push || !cv);
        sel_rr_clear = sel_push || (!cv && (qlen != '0));
      end
      default: ;
    endcase
  end

  // decision after the queue scan
  assign cur_arr = cv && ({8'd0, arr_rd} <= cyc);
  always_comb begin
    dec_take = 1'b0;
    dec_drop = 1'b0;
    case (algo)
      ALG_SJF: dec_take = found;
      ALG_SRT: begin
        dec_drop = !cur_arr && !found;
        dec_take = !(cur_arr && (!found || rem_rd < best_key)) && !dec_drop;
      end
      ALG_PRIO: dec_take = found && (!cv || best_key[7:0] < pri_rd);
      default: ;
    endcase
  end

  // remaining burst decrement of the running process
  assign rem_dec = (rem_rd == 16'd0) ? 16'd0 : rem_rd - 16'd1;
  assign run_fin = cv && (rem_dec == 16'd0) && !fin_rd;

  // queue write port and length
  always_comb begin
    case (cmd.op)
      OP_ARR:   push_req = !scan_end && ({8'd0, arr_rd} == cyc);
      OP_START: push_req = !scan_end && alg13 && idx_lt_n;
      default:  push_req = 1'b0;
    endcase
    q_we      = 1'b0;
    q_wa      = qlen[SW-1:0];
    q_wd      = ia;
    qlen_next = qlen;
    if (push_req && (32'(qlen) < MAX_PROCS)) begin
      q_we      = 1'b1;
      qlen_next = qlen + CW'(1);
    end
    if (cmd.op == OP_SHIFT) begin
      if (!scan_end) begin
        q_we = 1'b1;
        q_wa = SW'(idx - CW'(1));
        q_wd = q_rd;
      end else if (push_cur) begin
        q_we = 1'b1;
        q_wa = SW'(qlen - CW'(1));
        q_wd = cur;
      end else begin
        qlen_next = qlen - CW'(1);
      end
    end
    if ((cmd.op == OP_ACCEPT) && (in_command == CMD_START)) qlen_next = '0;
  end

  assign out_free = !m_valid || m_ready;
  assign res_load = (cmd.op == OP_RES) && out_free;

  assign status.scan_end = scan_end;
  assign status.sel_scan = sel_scan;
  assign status.sel_take = sel_take;
  assign status.dec_take = dec_take;
  assign status.out_free = out_free;

  // table and queue storage
  always_ff @(posedge clk) begin
    if ((cmd.op == OP_ACCEPT) && (in_command == CMD_LOAD) && load_ok) begin
      arr_mem[SW'(in_pidx)] <= in_arr;
      bur_mem[SW'(in_pidx)] <= in_bur;
      pri_mem[SW'(in_pidx)] <= in_pri;
    end
    if (q_we) q_mem[q_wa] <= q_wd;
  end

  // result fields
  assign o_tick = (in_cmd == CMD_TICK) ? cyc : 24'd0;
  assign o_slot = ran ? 4'(cur) : 4'd0;
  assign o_ccyc = comp ? ({1'b0, cyc} + 25'd1) : 25'd0;
  assign o_done = (in_cmd == CMD_TICK) && done_acc;

  always_ff @(posedge clk) begin
    if (res_load) m_data <= {o_done, o_ccyc, comp, o_slot, ran, o_tick};
  end

  // control and run state
  always_ff @(posedge clk) begin
    if (rst) begin
      algo       <= ALG_FIFO;
      quantum    <= 16'd2;
      pcount     <= 5'd0;
      qlen       <= '0;
      cv         <= 1'b0;
      cur        <= '0;
      slice      <= 16'd0;
      next_cycle <= 24'd0;
      m_valid    <= 1'b0;
      in_cmd     <= CMD_LOAD;
      cyc        <= 24'd0;
      idx        <= '0;
      found      <= 1'b0;
      best_pos   <= '0;
      best_key   <= 16'd0;
      push_cur   <= 1'b0;
      taken      <= '0;
      ran        <= 1'b0;
      comp       <= 1'b0;
      done_acc   <= 1'b0;
      for (int i = 0; i < MAX_PROCS; i++) begin
        rem_mem[i] <= 16'd0;
        fin[i]     <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ALGO:    algo    <= cfg_data[2:0];
          REG_QUANTUM: quantum <= cfg_data;
          REG_PCOUNT:  pcount  <= cfg_data[4:0];
          default: ;
        endcase
      end
      qlen <= qlen_next;
      if (res_load) m_valid <= 1'b1;
      else if (m_ready) m_valid <= 1'b0;

      case (cmd.op)
        OP_ACCEPT: begin
          in_cmd   <= in_command;
          ran      <= 1'b0;
          comp     <= 1'b0;
          done_acc <= 1'b0;
          idx      <= '0;
          if (in_command == CMD_START) begin
            cv         <= 1'b0;
            cur        <= '0;
            slice      <= 16'd0;
            next_cycle <= 24'd0;
          end
          if (in_command == CMD_TICK) begin
            cyc <= next_cycle;
            if (next_cycle != CYCLE_MAX) next_cycle <= next_cycle + 24'd1;
          end
        end
        OP_START: begin
          if (!scan_end) begin
            rem_mem[ia] <= idx_lt_n ? bur_rd : 16'd0;
            fin[ia]     <= 1'b0;
            idx         <= idx + CW'(1);
          end
        end
        OP_ARR: begin
          if (!scan_end) idx <= idx + CW'(1);
        end
        OP_SEL: begin
          idx      <= '0;
          found    <= 1'b0;
          best_key <= 16'd0;
          push_cur <= sel_push;
          if (sel_rr_clear) slice <= 16'd0;
        end
        OP_SCAN: begin
          if (!scan_end) begin
            if (scan_hit) begin
              best_pos <= ia;
              best_key <= key;
              found    <= 1'b1;
            end
            idx <= idx + CW'(1);
          end
        end
        OP_DEC: begin
          idx      <= CW'(best_pos);
          push_cur <= cv;
          if (dec_drop) cv <= 1'b0;
        end
        OP_TAKE: begin
          taken <= q_rd;
          idx   <= idx + CW'(1);
        end
        OP_SHIFT: begin
          if (!scan_end) begin
            idx <= idx + CW'(1);
          end else begin
            cur <= taken;
            cv  <= 1'b1;
          end
        end
        OP_RUN: begin
          ran      <= cv;
          idx      <= '0;
          done_acc <= !(cv && !run_fin) && (qlen == '0);
          if (cv) begin
            rem_mem[cur] <= rem_dec;
            if (run_fin) begin
              fin[cur] <= 1'b1;
              comp     <= 1'b1;
              cv       <= 1'b0;
              slice    <= 16'd0;
            end else if ((algo == ALG_RR) && (slice != SLICE_MAX)) begin
              slice <= slice + 16'd1;
            end
          end
        end
        OP_DONE: begin
          if (!scan_end) begin
            if (rem_rd != 16'd0) done_acc <= 1'b0;
            idx <= idx + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> src/cps_ctrl.sv
// scheduler controller: sequences the steps of each item
module cps_ctrl import cps_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_valid,
  input  logic [1:0] s_command,
  output logic       s_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] ST_IDLE  = 4'd0;
  localparam logic [ST_W-1:0] ST_START = 4'd1;
  localparam logic [ST_W-1:0] ST_ARR   = 4'd2;
  localparam logic [ST_W-1:0] ST_SEL   = 4'd3;
  localparam logic [ST_W-1:0] ST_SCAN  = 4'd4;
  localparam logic [ST_W-1:0] ST_DEC   = 4'd5;
  localparam logic [ST_W-1:0] ST_TAKE  = 4'd6;
  localparam logic [ST_W-1:0] ST_SHIFT = 4'd7;
  localparam logic [ST_W-1:0] ST_RUN   = 4'd8;
  localparam logic [ST_W-1:0] ST_DONE  = 4'd9;
  localparam logic [ST_W-1:0] ST_RES   = 4'd10;

  logic [ST_W-1:0] state, state_next;

  assign s_ready = (state == ST_IDLE);

  // next state and datapath operation
  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    case (state)
      ST_IDLE: begin
        if (s_valid) begin
          cmd.op = OP_ACCEPT;
          case (s_command)
            CMD_START: state_next = ST_START;
            CMD_TICK:  state_next = ST_ARR;
            default:   state_next = ST_RES;
          endcase
        end
      end
      ST_START: begin
        cmd.op = OP_START;
        if (status.scan_end) state_next = ST_RES;
      end
      ST_ARR: begin
        cmd.op = OP_ARR;
        if (status.scan_end) state_next = ST_SEL;
      end
      ST_SEL: begin
        cmd.op = OP_SEL;
        if (status.sel_scan) state_next = ST_SCAN;
        else if (status.sel_take) state_next = ST_TAKE;
        else state_next = ST_RUN;
      end
      ST_SCAN: begin
        cmd.op = OP_SCAN;
        if (status.scan_end) state_next = ST_DEC;
      end
      ST_DEC: begin
        cmd.op = OP_DEC;
        state_next = status.dec_take ? ST_TAKE : ST_RUN;
      end
      ST_TAKE: begin
        cmd.op     = OP_TAKE;
        state_next = ST_SHIFT;
      end
      ST_SHIFT: begin
        cmd.op = OP_SHIFT;
        if (status.scan_end) state_next = ST_RUN;
      end
      ST_RUN: begin
        cmd.op     = OP_RUN;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        cmd.op = OP_DONE;
        if (status.scan_end) state_next = ST_RES;
      end
      ST_RES: begin
        cmd.op = OP_RES;
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

endmodule

>>> src/cpu_process_scheduler.sv
// cpu process scheduler: one item at a time, result held in an output register
// a tick handles one table or queue entry per cycle in the arrival, queue scan, queue
//   removal and completion passes
// items: the next item is taken once the result of the last one is in the output
//   register, even if it has not been transferred yet
// reset: synchronous, clears run state and registers; tables hold until loaded
module cpu_process_scheduler import cps_pkg::*; #(
  parameter int MAX_PROCS = DEF_MAX_PROCS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // process_index[3:0], arrival_time[19:4], burst_length[35:20],
  // priority_level[43:36], zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // command[1:0]
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tick_cycle[23:0], running_valid[24], running_slot[28:25],
  // completed_valid[29], completion_cycle[54:30], all_done[55]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  cps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_valid   (s_axis_tvalid),
    .s_command (s_axis_tuser),
    .s_ready   (s_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  cps_datapath #(.MAX_PROCS(MAX_PROCS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .in_command (s_axis_tuser),
    .in_data    (s_axis_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .m_valid    (m_axis_tvalid),
    .m_ready    (m_axis_tready),
    .m_data     (m_axis_tdata)
  );

endmodule

>>> src/cps_checker.sv
// port checker for the cpu process scheduler, bound to the top level
`include "assert_macros.svh"

module cps_checker import cps_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // a stalled result holds
  `CPS_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // one item at a time: busy right after a transfer in
  `CPS_ASSERT_NEXT(a_busy_after_in, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while busy")

  // completion only for a running process
  `CPS_ASSERT_SAME(a_comp_runs, clk, rst, m_axis_tvalid && m_axis_tdata[29], m_axis_tdata[24], "completion without a running process")

  // completion cycle only with completion
  `CPS_ASSERT_SAME(a_comp_cycle, clk, rst, m_axis_tvalid && !m_axis_tdata[29], m_axis_tdata[54:30] == 25'd0, "completion cycle without completion")

endmodule

bind cpu_process_scheduler cps_checker u_cps_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> bench/tb.sv
// testbench for the cpu process scheduler: directed and random items against a local predictor
`timescale 1ns / 100ps

module tb;
  import cps_pkg::*;

  localparam int NPROC = 16;
  localparam logic [1:0] CMD_BAD = 2'd3;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [1:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we;
  logic [1:0]            cfg_index;
  logic [15:0]           cfg_data;

  cpu_process_scheduler dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // expected result of one scheduler step
  typedef struct packed {
    logic        all_done;
    logic [24:0] completion_cycle;
    logic        completed_valid;
    logic [3:0]  running_slot;
    logic        running_valid;
    logic [23:0] tick_cycle;
  } sched_result_t;

  sched_result_t sched_expect_q[$];
  int errors = 0;

  // scheduler shadow state
  logic [2:0]  sh_alg;
  logic [15:0] sh_quantum;
  logic [4:0]  sh_pcount;
  logic [15:0] sh_arr[NPROC];
  logic [15:0] sh_bur[NPROC];
  logic [7:0]  sh_pri[NPROC];
  logic [15:0] sh_rem[NPROC];
  logic        sh_fin[NPROC];
  logic [3:0]  sh_rq[NPROC];
  int          sh_qlen;
  logic        sh_cur_v;
  logic [3:0]  sh_cur;
  logic [15:0] sh_slice;
  logic [23:0] sh_next;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic void rq_push(logic [3:0] slot);
    if (sh_qlen < NPROC) begin
      sh_rq[sh_qlen] = slot;
      sh_qlen++;
    end
  endfunction

  function automatic logic [3:0] rq_take(int pos);
    logic [3:0] v;
    v = sh_rq[pos];
    for (int i = pos; i + 1 < sh_qlen; i++) sh_rq[i] = sh_rq[i + 1];
    sh_qlen--;
    return v;
  endfunction

  function automatic int valid_procs();
    return (sh_pcount > NPROC) ? NPROC : int'(sh_pcount);
  endfunction

  // pick the process to run on this tick
  function automatic void pick_process(logic [23:0] cyc);
    int best;
    bit found;
    logic [3:0] slot;
    logic [15:0] bestrem;
    best = 0;
    found = 0;
    bestrem = 0;
    case (sh_alg)
      ALG_FIFO: begin
        if (!sh_cur_v && sh_qlen > 0) begin
          sh_cur = rq_take(0);
          sh_cur_v = 1'b1;
        end
      end
      ALG_SJF: begin
        if (!sh_cur_v) begin
          for (int i = 0; i < sh_qlen; i++) begin
            slot = sh_rq[i];
            if (sh_arr[slot] <= cyc && (!found || sh_bur[slot] < sh_bur[sh_rq[best]])) begin
              best = i;
              found = 1;
            end
          end
          if (found) begin
            sh_cur = rq_take(best);
            sh_cur_v = 1'b1;
          end
        end
      end
      ALG_SRT: begin
        for (int i = 0; i < sh_qlen; i++) begin
          slot = sh_rq[i];
          if (sh_arr[slot] <= cyc && (!found || sh_rem[slot] < bestrem)) begin
            best = i;
            bestrem = sh_rem[slot];
            found = 1;
          end
        end
        if (sh_cur_v && sh_arr[sh_cur] <= cyc) begin
          if (!found || sh_rem[sh_cur] < bestrem) return;
        end else if (!found) begin
          sh_cur_v = 1'b0;
          return;
        end
        slot = rq_take(best);
        if (sh_cur_v) rq_push(sh_cur);
        sh_cur = slot;
        sh_cur_v = 1'b1;
      end
      ALG_PRIO: begin
        for (int i = 0; i < sh_qlen; i++) begin
          slot = sh_rq[i];
          if (sh_arr[slot] <= cyc && (!found || sh_pri[slot] < sh_pri[sh_rq[best]])) begin
            best = i;
            found = 1;
          end
        end
        if (found && (!sh_cur_v || sh_pri[sh_rq[best]] < sh_pri[sh_cur])) begin
          slot = rq_take(best);
          if (sh_cur_v) rq_push(sh_cur);
          sh_cur = slot;
          sh_cur_v = 1'b1;
        end
      end
      ALG_RR: begin
        if (sh_cur_v && sh_slice >= sh_quantum) begin
          sh_slice = 0;
          if (sh_qlen > 0) begin
            slot = rq_take(0);
            rq_push(sh_cur);
            sh_cur = slot;
          end
        end
        if (!sh_cur_v && sh_qlen > 0) begin
          sh_cur = rq_take(0);
          sh_cur_v = 1'b1;
          sh_slice = 0;
        end
      end
      default: ;
    endcase
  endfunction

  // one scheduler step: load, start or tick
  function automatic sched_result_t sched_step(logic [1:0] cmd, logic [3:0] idx,
      logic [15:0] arr, logic [15:0] bur, logic [7:0] pri);
    sched_result_t r;
    int n;
    logic [23:0] cyc;
    bit ran, comp, done;
    logic [3:0] ran_slot;
    r = '0;
    n = valid_procs();
    if (cmd == CMD_LOAD) begin
      sh_arr[idx] = arr;
      sh_bur[idx] = bur;
      sh_pri[idx] = pri;
      return r;
    end
    if (cmd == CMD_START) begin
      sh_qlen = 0;
      sh_cur_v = 1'b0;
      sh_cur = 0;
      sh_slice = 0;
      sh_next = 0;
      for (int i = 0; i < NPROC; i++) begin
        sh_rem[i] = (i < n) ? sh_bur[i] : 16'd0;
        sh_fin[i] = 1'b0;
      end
      if (sh_alg == ALG_SJF || sh_alg == ALG_PRIO)
        for (int i = 0; i < n; i++) rq_push(i[3:0]);
      return r;
    end
    if (cmd != CMD_TICK) return r;

    cyc = sh_next;
    if (sh_next < CYCLE_MAX) sh_next++;
    // arrivals
    if (sh_alg == ALG_FIFO || sh_alg == ALG_SRT || sh_alg == ALG_RR)
      for (int i = 0; i < n; i++)
        if ({8'd0, sh_arr[i]} == cyc) rq_push(i[3:0]);
    if (sh_alg == ALG_SRT || sh_alg == ALG_PRIO || sh_alg == ALG_RR || !sh_cur_v)
      pick_process(cyc);
    // run and completion
    ran = sh_cur_v;
    ran_slot = sh_cur;
    comp = 0;
    if (ran) begin
      if (sh_rem[ran_slot] > 0) sh_rem[ran_slot]--;
      if (sh_alg == ALG_RR && sh_slice < SLICE_MAX) sh_slice++;
      if (sh_rem[ran_slot] == 0 && !sh_fin[ran_slot]) begin
        sh_fin[ran_slot] = 1'b1;
        comp = 1;
        sh_cur_v = 1'b0;
        sh_slice = 0;
      end
    end
    done = !sh_cur_v && sh_qlen == 0;
    for (int i = 0; i < n; i++) if (sh_rem[i] != 0) done = 0;
    r.tick_cycle = cyc;
    r.running_valid = ran;
    r.running_slot = ran ? ran_slot : 4'd0;
    r.completed_valid = comp;
    r.completion_cycle = comp ? {1'b0, cyc} + 25'd1 : 25'd0;
    r.all_done = done;
    return r;
  endfunction

  // send one item; valid stays high into a back-to-back item
  task automatic send_item(logic [1:0] cmd, logic [3:0] idx, logic [15:0] arr,
      logic [15:0] bur, logic [7:0] pri);
    int gap, pick;
    bit rdy;
    pick = $urandom_range(0, 99);
    gap = (pick < 65) ? 0 : (pick < 95) ? $urandom_range(1, 3) : $urandom_range(10, 50);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {4'd0, pri, bur, arr, idx};
    do begin
      @(negedge clk);
      rdy = s_axis_tready;
      @(posedge clk);
    end while (!rdy);
    sched_expect_q.insert(sched_expect_q.size(), sched_step(cmd, idx, arr, bur, pri));
  endtask

  // item of the given kind with random field values
  task automatic send_random_fields(logic [1:0] cmd);
    send_item(cmd, 4'($urandom()), 16'($urandom()), 16'($urandom()), 8'($urandom()));
  endtask

  // let the block drain before touching registers
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sched_expect_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] index, logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      REG_ALGO:    sh_alg = value[2:0];
      REG_QUANTUM: sh_quantum = value;
      REG_PCOUNT:  sh_pcount = value[4:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [15:0] alg, logic [15:0] quantum, logic [15:0] pcount);
    wait_idle();
    write_reg(REG_ALGO, alg);
    write_reg(REG_QUANTUM, quantum);
    write_reg(REG_PCOUNT, pcount);
  endtask

  task automatic send_tick();
    send_random_fields(CMD_TICK);
  endtask

  // random process entry, mostly small times, now and then extremes
  task automatic load_random(logic [3:0] idx);
    logic [15:0] arr, bur;
    arr = ($urandom_range(0, 19) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 24));
    bur = ($urandom_range(0, 19) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 6));
    send_item(CMD_LOAD, idx, arr, bur, 8'($urandom()));
  endtask

  // directed: table extremes, zero burst, every command, late arrival
  task automatic test_directed();
    set_config(ALG_FIFO, 16'd2, 16'd16);
    send_item(CMD_LOAD, 4'd0, 16'd0, 16'd0, 8'd0);
    send_item(CMD_LOAD, 4'd15, 16'hFFFF, 16'hFFFF, 8'hFF);
    for (int i = 1; i < 15; i++) send_item(CMD_LOAD, i[3:0], i[15:0], 16'd1, 8'(15 - i));
    send_item(CMD_START, 4'd0, 16'd0, 16'd0, 8'd0);
    repeat (6) send_tick();
    send_item(CMD_BAD, 4'hF, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_tick();
  endtask

  // one random run under the current setting
  task automatic run_phase(int ticks);
    repeat ($urandom_range(0, 6)) load_random(4'($urandom()));
    if ($urandom_range(0, 5) != 0) send_random_fields(CMD_START);
    for (int i = 0; i < ticks; i++) begin
      case ($urandom_range(0, 39))
        0: load_random(4'($urandom()));
        1: send_random_fields(CMD_BAD);
        2: send_random_fields(CMD_START);
        default: send_tick();
      endcase
    end
  endtask

  // every algorithm, including the undefined codes, with extreme settings
  task automatic test_algorithms();
    for (int a = 0; a < 8; a++) begin
      set_config(16'(a), 16'd1, 16'd16);
      run_phase(40);
      set_config(16'(a), 16'hFFFF, 16'd31);
      run_phase(40);
    end
  endtask

  // round robin with quantum zero and small quanta, and process counts down to zero
  task automatic test_round_robin();
    set_config(ALG_RR, 16'd0, 16'd5);
    run_phase(50);
    set_config(ALG_RR, 16'd2, 16'd0);
    run_phase(20);
    set_config(ALG_RR, 16'd3, 16'd1);
    run_phase(40);
  endtask

  task automatic test_random();
    for (int p = 0; p < 22; p++) begin
      set_config(16'($urandom_range(0, 7)),
                 ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 4)),
                 ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 31)) :
                                               16'($urandom_range(1, 16)));
      run_phase($urandom_range(25, 60));
    end
  endtask

  // result side: random stalls, transfer sampled away from the edge
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 149) == 0) begin
      stall_left <= $urandom_range(20, 80);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // compare each transfer with the oldest expectation
  always @(negedge clk) begin
    sched_result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (sched_expect_q.size() == 0) begin
        $display("%t unexpected result %h", $realtime, got);
        errors++;
      end else begin
        want = sched_expect_q[0];
        sched_expect_q.delete(0);
        if (got.tick_cycle != want.tick_cycle) begin
          $display("%t tick_cycle exp %0d got %0d", $realtime, want.tick_cycle, got.tick_cycle);
          errors++;
        end
        if (got.running_valid != want.running_valid) begin
          $display("%t running_valid exp %0d got %0d", $realtime,
                   want.running_valid, got.running_valid);
          errors++;
        end
        if (got.running_slot != want.running_slot) begin
          $display("%t running_slot exp %0d got %0d", $realtime,
                   want.running_slot, got.running_slot);
          errors++;
        end
        if (got.completed_valid != want.completed_valid) begin
          $display("%t completed_valid exp %0d got %0d", $realtime,
                   want.completed_valid, got.completed_valid);
          errors++;
        end
        if (got.completion_cycle != want.completion_cycle) begin
          $display("%t completion_cycle exp %0d got %0d", $realtime,
                   want.completion_cycle, got.completion_cycle);
          errors++;
        end
        if (got.all_done != want.all_done) begin
          $display("%t all_done exp %0d got %0d", $realtime, want.all_done, got.all_done);
          errors++;
        end
      end
    end
  end

  initial begin
    int waited;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = CMD_LOAD;
    cfg_we = 1'b0;
    cfg_index = REG_ALGO;
    cfg_data = '0;
    sh_alg = ALG_FIFO;
    sh_quantum = 16'd2;
    sh_pcount = 5'd0;
    sh_qlen = 0;
    sh_cur_v = 1'b0;
    sh_cur = 0;
    sh_slice = 0;
    sh_next = 0;
    for (int i = 0; i < NPROC; i++) begin
      sh_arr[i] = 0; sh_bur[i] = 0; sh_pri[i] = 0;
      sh_rem[i] = 0; sh_fin[i] = 0; sh_rq[i] = 0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_algorithms();
    test_round_robin();
    test_random();

    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (sched_expect_q.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (200) @(posedge clk);
    if (errors == 0 && sched_expect_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
